// ===== sv/tmpc_pkg.sv =====
// Shared types, register indexes and arithmetic constants for the text mask colouriser.
// Used by every module of the block; depends on nothing else.
package tmpc_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_RED   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_GREEN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_BLUE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIT_FILL   = 3'd3;

    // Luminance weights and the dark-text threshold.
    localparam logic [9:0]  LUMA_R     = 10'd299;
    localparam logic [9:0]  LUMA_G     = 10'd587;
    localparam logic [9:0]  LUMA_B     = 10'd114;
    localparam logic [17:0] LUMA_LIMIT = 18'd128000;

    // floor(s / 3) = (s * 683) >> 11 for every sum up to 766.
    localparam logic [9:0]  RECIP_3    = 10'd683;
    localparam int unsigned SHIFT_3    = 11;
    // floor(x / 255) = (x * 32897) >> 23 for every x up to 65152.
    localparam logic [15:0] RECIP_255  = 16'd32897;
    localparam int unsigned SHIFT_255  = 23;
    localparam logic [7:0]  ROUND_255  = 8'd127;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [7:0] mask_red;
        logic [7:0] mask_green;
        logic [7:0] mask_blue;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_frame_end;
    } out_t;

    typedef struct packed {
        logic [7:0] text_red;
        logic [7:0] text_green;
        logic [7:0] text_blue;
        logic       hit_fill_enable;
        logic       text_dark;
    } cfg_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic       frame_end;
    } cov_t;

endpackage

// ===== sv/text_mask_premultiply_colorizer_core.sv =====
// Text mask colouriser: mask pixels of black-on-white text in, premultiplied ARGB out.
// Depends on tmpc_pkg, tmpc_cfg, tmpc_alpha and tmpc_premul.
//
// Use: mask pixels arrive on the s_ channel (valid/ready), one transfer per pixel,
// and each produces exactly one ARGB transfer on the m_ channel, in order.
// The text colour and the hit-fill enable are set through a plain write port
// (cfg_wr_en, cfg_addr, cfg_wr_data) while no pixel is in flight; indexes past
// the last register are ignored.
// The pipeline is four register stages; m_valid is the valid bit of the last one.
// The stages are a sum stage, a divide-by-three stage, a colour multiply stage
// and a divide-by-255 stage that also selects the hit pixel and feeds the output
// register.
// Throughput is one pixel per cycle while m_ready stays high; each stage holds one
// pixel and its valid bit, and the multipliers set the stage depth.
// When the receiver stalls, the output register holds its pixel and the
// stages behind it fill up; s_ready falls only once all four stages are full,
// so no pixel is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads white text
// with hit fill enabled.
module text_mask_premultiply_colorizer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tmpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tmpc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tmpc_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tmpc_pkg::out_t                  m_data
);

    tmpc_pkg::cfg_t cfg;
    tmpc_pkg::cov_t cov_data;
    logic           cov_valid;
    logic           cov_ready;

    // The register block also keeps the dark-text flag used by the hit pixel.
    tmpc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // First half of the pipeline: coverage alpha from the mask channels.
    tmpc_alpha u_alpha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (cov_valid),
        .out_ready (cov_ready),
        .out_data  (cov_data)
    );

    // Second half: premultiplied colour, hit pixel and the output register.
    tmpc_premul u_premul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (cov_valid),
        .in_ready  (cov_ready),
        .in_data   (cov_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== sv/tmpc_cfg.sv =====
// Configuration registers and the registered dark-text flag of the colouriser.
// Depends on tmpc_pkg.
module tmpc_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tmpc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output tmpc_pkg::cfg_t                    cfg
);

    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        hit_reg, dark_reg;
    logic [17:0] luma;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= 8'd255;
            green_reg <= 8'd255;
            blue_reg  <= 8'd255;
            hit_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tmpc_pkg::REG_TEXT_RED:   red_reg   <= cfg_wr_data;
                tmpc_pkg::REG_TEXT_GREEN: green_reg <= cfg_wr_data;
                tmpc_pkg::REG_TEXT_BLUE:  blue_reg  <= cfg_wr_data;
                tmpc_pkg::REG_HIT_FILL:   hit_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Weighted sum of the text colour, combinational from the registers.
    assign luma = 18'(tmpc_pkg::LUMA_R) * 18'(red_reg)
                + 18'(tmpc_pkg::LUMA_G) * 18'(green_reg)
                + 18'(tmpc_pkg::LUMA_B) * 18'(blue_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg <= 1'b0;
        end else begin
            dark_reg <= (luma < tmpc_pkg::LUMA_LIMIT);
        end
    end

    assign cfg.text_red        = red_reg;
    assign cfg.text_green      = green_reg;
    assign cfg.text_blue       = blue_reg;
    assign cfg.hit_fill_enable = hit_reg;
    assign cfg.text_dark       = dark_reg;

endmodule

// ===== sv/tmpc_alpha.sv =====
// Two pipeline stages that turn a mask pixel into its coverage alpha.
// Depends on tmpc_pkg.
module tmpc_alpha (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tmpc_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tmpc_pkg::cov_t out_data
);

    logic       a_valid_reg, b_valid_reg;
    logic       a_load, b_load, b_ready;
    logic [9:0] sum_reg, sum_next;
    logic       a_fe_reg;
    tmpc_pkg::cov_t b_data_reg, b_data_next;
    logic [19:0] mean_prod;

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign a_load   = in_valid && in_ready;
    assign b_load   = a_valid_reg && b_ready;

    // Sum of the channels plus one, so the divide by three rounds.
    assign sum_next = 10'(in_data.mask_red) + 10'(in_data.mask_green)
                    + 10'(in_data.mask_blue) + 10'd1;

    assign mean_prod = sum_reg * tmpc_pkg::RECIP_3;
    assign b_data_next.alpha = tmpc_pkg::FULL_SCALE
                             - mean_prod[tmpc_pkg::SHIFT_3 +: 8];
    assign b_data_next.frame_end = a_fe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            sum_reg  <= sum_next;
            a_fe_reg <= in_data.frame_end;
        end
        if (b_load) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ===== sv/tmpc_premul.sv =====
// Two pipeline stages that premultiply the text colour and apply the hit pixel.
// Depends on tmpc_pkg.
module tmpc_premul (
    input  logic           aclk,
    input  logic           aresetn,
    input  tmpc_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  tmpc_pkg::cov_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tmpc_pkg::out_t out_data
);

    logic        c_valid_reg, d_valid_reg;
    logic        c_load, d_load, d_ready;
    logic [15:0] red_prod_reg, green_prod_reg, blue_prod_reg;
    logic [15:0] red_prod_next, green_prod_next, blue_prod_next;
    tmpc_pkg::cov_t c_cov_reg;
    logic [31:0] red_q, green_q, blue_q;
    tmpc_pkg::out_t d_data_reg, d_data_next;
    logic        hit;

    assign d_ready  = !d_valid_reg || out_ready;
    assign in_ready = !c_valid_reg || d_ready;
    assign c_load   = in_valid && in_ready;
    assign d_load   = c_valid_reg && d_ready;

    assign red_prod_next   = cfg.text_red * in_data.alpha + 16'(tmpc_pkg::ROUND_255);
    assign green_prod_next = cfg.text_green * in_data.alpha + 16'(tmpc_pkg::ROUND_255);
    assign blue_prod_next  = cfg.text_blue * in_data.alpha + 16'(tmpc_pkg::ROUND_255);

    // Divide by 255 as a multiply by the scaled reciprocal.
    assign red_q   = red_prod_reg * tmpc_pkg::RECIP_255;
    assign green_q = green_prod_reg * tmpc_pkg::RECIP_255;
    assign blue_q  = blue_prod_reg * tmpc_pkg::RECIP_255;

    assign hit = cfg.hit_fill_enable && (c_cov_reg.alpha == 8'd0);

    always_comb begin
        d_data_next.out_frame_end = c_cov_reg.frame_end;
        if (hit) begin
            d_data_next.out_alpha = 8'd1;
            d_data_next.out_red   = {7'd0, cfg.text_dark};
            d_data_next.out_green = {7'd0, cfg.text_dark};
            d_data_next.out_blue  = {7'd0, cfg.text_dark};
        end else begin
            d_data_next.out_alpha = c_cov_reg.alpha;
            d_data_next.out_red   = red_q[tmpc_pkg::SHIFT_255 +: 8];
            d_data_next.out_green = green_q[tmpc_pkg::SHIFT_255 +: 8];
            d_data_next.out_blue  = blue_q[tmpc_pkg::SHIFT_255 +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            red_prod_reg   <= red_prod_next;
            green_prod_reg <= green_prod_next;
            blue_prod_reg  <= blue_prod_next;
            c_cov_reg      <= in_data;
        end
        if (d_load) begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

// ===== sv/tmpc_checker.sv =====
// Port-level checks for the colouriser and the bind that attaches them.
// Depends on tmpc_pkg and text_mask_premultiply_colorizer_core.
module tmpc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input tmpc_pkg::out_t m_data
);

    logic [2:0] inflight_reg, inflight_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (out_xfer && !in_xfer) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 3'd0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // No result without a pixel in flight, and never more than four in flight.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("result without an accepted pixel");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd4)
        else $error("more pixels in flight than pipeline stages");

    // Zero coverage always carries a black colour.
    a_zero_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_alpha == 8'd0 |->
            m_data.out_red == 8'd0 && m_data.out_green == 8'd0 && m_data.out_blue == 8'd0)
        else $error("transparent pixel with colour");

endmodule

bind text_mask_premultiply_colorizer_core tmpc_checker u_tmpc_checker (.*);
